[src/zbdt_pkg.sv]
// zbdt_pkg: shared types and constants of the depth-test unit
// word layouts for fragments and results, register indexes, outcome codes
// no dependencies
package zbdt_pkg;

  localparam int CFG_W       = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int COUNT_W     = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] FRAME_RESET = 9'd256;

  localparam logic [1:0] OUT_DRAWN   = 2'd0;
  localparam logic [1:0] OUT_OUTSIDE = 2'd1;
  localparam logic [1:0] OUT_HIDDEN  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [31:0] depth;
  } frag_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic               draw;
    logic [COUNT_W-1:0] drawn_total;
    logic [COUNT_W-1:0] outside_total;
    logic [COUNT_W-1:0] hidden_total;
  } result_t;

endpackage

[src/zbdt_store.sv]
// zbdt_store: depth store, one write port and one registered read port
// plain synchronous memory, no reset; clearing is sequenced by the core
// no dependencies
module zbdt_store #(
  parameter int ENTRIES = 65536,
  parameter int DATA_W  = 32,
  parameter int ADDR_W  = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/zbuffer_depth_test_core.sv]
// zbuffer_depth_test_core: depth-buffer test unit, top level
// depends on zbdt_pkg and zbdt_store
//
// usage:
//   a fragment word (frag) is taken at a rising edge where start is high and
//   busy is low. the unit looks up the stored depth at row*width+column, keeps
//   the fragment depth when it is strictly nearer and counts the fragment as
//   drawn, occluded or out of bounds.
//   one result word per fragment appears on result with done high for exactly
//   one cycle; the receiver cannot stall, so the word must be taken then.
//   steps: the accepting edge registers the fragment, then come calc address,
//   registered store read, and compare and write back, which registers done
//   and the result word. one fragment is in flight at a time, so the next is
//   not taken before the last is through. busy drops in the cycle done is
//   high, so the next fragment can be taken alongside the previous result.
//   configuration: cfg_we/cfg_index/cfg_data write frame_width (index 0) or
//   frame_height (index 1) at any edge; write them only while the unit is idle.
//   reset: counters go to zero, both frame sizes to 256, then the store is
//   swept to the most negative depth, one entry a cycle, with busy high
//   until every entry is cleared.
module zbuffer_depth_test_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int DEPTH_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  zbdt_pkg::frag_t                  frag,
  input  logic                             cfg_we,
  input  logic [zbdt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [zbdt_pkg::CFG_W-1:0]       cfg_data,
  output logic                             done,
  output zbdt_pkg::result_t                result
);

  import zbdt_pkg::*;

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);
  localparam logic signed [63:0] ZMIN64 = -(64'sd1 <<< (DEPTH_BITS - 1));
  localparam logic signed [63:0] ZMAX64 = ~ZMIN64;
  localparam logic [DEPTH_BITS-1:0] ZMIN = ZMIN64[DEPTH_BITS-1:0];

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [CFG_W-1:0]      frame_width;
  logic [CFG_W-1:0]      frame_height;
  logic [ADDR_W-1:0]     clr_addr;
  frag_t                 frag_q;
  logic [ADDR_W-1:0]     idx_q;
  logic                  inb_q;
  logic [DEPTH_BITS-1:0] z_q;
  logic [COUNT_W-1:0]    drawn_count;
  logic [COUNT_W-1:0]    outside_count;
  logic [COUNT_W-1:0]    hidden_count;
  logic [COUNT_W-1:0]    drawn_next;
  logic [COUNT_W-1:0]    outside_next;
  logic [COUNT_W-1:0]    hidden_next;

  logic [CFG_W-1:0]      w_eff;
  logic [CFG_W-1:0]      h_eff;
  logic                  x_ok;
  logic                  y_ok;
  logic [17:0]           lin;
  logic [ADDR_W+17:0]    lin_ext;
  logic signed [63:0]    z64;
  logic signed [63:0]    z_sat;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [DEPTH_BITS-1:0] mem_wdata;
  logic [DEPTH_BITS-1:0] rd_data;
  logic                  pass;
  logic                  accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_RESET;
      frame_height <= FRAME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame clamp, bounds, linear address and depth saturation
  always_comb begin
    w_eff   = (32'(frame_width) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : frame_width;
    h_eff   = (32'(frame_height) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : frame_height;
    x_ok    = !frag_q.pos_x[15] && ($unsigned(frag_q.pos_x) < {7'b0, w_eff});
    y_ok    = !frag_q.pos_y[15] && ($unsigned(frag_q.pos_y) < {7'b0, h_eff});
    lin     = {9'b0, frag_q.pos_y[8:0]} * {9'b0, w_eff} + {9'b0, frag_q.pos_x[8:0]};
    lin_ext = {{ADDR_W{1'b0}}, lin};
    z64     = {{32{frag_q.depth[31]}}, frag_q.depth};
    if (z64 < ZMIN64) begin
      z_sat = ZMIN64;
    end else if (z64 > ZMAX64) begin
      z_sat = ZMAX64;
    end else begin
      z_sat = z64;
    end
  end

  assign pass = inb_q && ($signed(z_q) > $signed(rd_data));

  always_comb begin
    drawn_next   = drawn_count;
    outside_next = outside_count;
    hidden_next  = hidden_count;
    if (!inb_q) begin
      outside_next = (outside_count == COUNT_MAX) ? outside_count : outside_count + 32'd1;
    end else if (pass) begin
      drawn_next = (drawn_count == COUNT_MAX) ? drawn_count : drawn_count + 32'd1;
    end else begin
      hidden_next = (hidden_count == COUNT_MAX) ? hidden_count : hidden_count + 32'd1;
    end
  end

  // store write port: clearing sweep or write-back of a passing fragment
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = z_q;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = ZMIN;
    end else if (state == S_CMP && pass) begin
      mem_we = 1'b1;
    end
  end

  zbdt_store #(
    .ENTRIES (STORE_SIZE),
    .DATA_W  (DEPTH_BITS),
    .ADDR_W  (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (state == S_READ),
    .raddr (idx_q),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == LAST_ADDR) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_CALC;
      S_CALC:  state_next = S_READ;
      S_READ:  state_next = S_CMP;
      S_CMP:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      done          <= 1'b0;
      drawn_count   <= '0;
      outside_count <= '0;
      hidden_count  <= '0;
    end else begin
      state <= state_next;
      done  <= (state == S_CMP);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_CMP) begin
        drawn_count   <= drawn_next;
        outside_count <= outside_next;
        hidden_count  <= hidden_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      frag_q <= frag;
    end
    if (state == S_CALC) begin
      inb_q <= x_ok && y_ok;
      idx_q <= lin_ext[ADDR_W-1:0];
      z_q   <= z_sat[DEPTH_BITS-1:0];
    end
    if (state == S_CMP) begin
      result.outcome       <= !inb_q ? OUT_OUTSIDE : (pass ? OUT_DRAWN : OUT_HIDDEN);
      result.draw          <= pass;
      result.drawn_total   <= drawn_next;
      result.outside_total <= outside_next;
      result.hidden_total  <= hidden_next;
    end
  end

endmodule

[src/zbdt_checker.sv]
// zbdt_checker: port-level checks of the depth-test unit, bound to the top level
// depends on zbdt_pkg and zbuffer_depth_test_core
module zbdt_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input zbdt_pkg::result_t result
);

  import zbdt_pkg::*;

  // every accepted word yields its result strobe on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("result word missing four cycles after accept");

  // a result strobe never runs into a second one
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_idle_on_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("unit busy while presenting a result");

  a_draw_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.draw == (result.outcome == OUT_DRAWN)))
    else $error("draw flag disagrees with outcome");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.outcome == OUT_DRAWN || result.outcome == OUT_OUTSIDE ||
              result.outcome == OUT_HIDDEN))
    else $error("unknown outcome code");

endmodule

bind zbuffer_depth_test_core zbdt_checker u_zbdt_checker (.*);
